/* hdl/lsfb_pkg.sv */
// ----------------------------------------------------------------------------
// lsfb_pkg
// Shared constants and types for the LED strip frame builder.
// ----------------------------------------------------------------------------
package lsfb_pkg;

	localparam int NUM_LEDS   = 8;
	localparam int START_LEN  = 4;
	localparam int FRAME_LEN  = 5 * NUM_LEDS + 8;
	localparam int CNT_W      = $clog2(FRAME_LEN);
	localparam int LED_W      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] BRIGHT_MAX  = 16'h02FD;
	localparam logic [7:0]  LED_HEADER  = 8'hF0;
	localparam logic [7:0]  ALL_LEDS    = 8'hFF;
	// floor(v * 683 / 2048) == floor(v / 3) for v <= 765
	localparam logic [10:0] RECIP3      = 11'd683;
	localparam int          RECIP3_SHIFT = 11;

	// one classified request waiting for the serializer
	typedef struct packed {
		logic [7:0] col_a;
		logic [7:0] col_b;
		logic [7:0] col_c;
		logic [7:0] mask;
	} lsfb_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} lsfb_qstat_t;

endpackage

/* hdl/lsfb_req_if.sv */
// ----------------------------------------------------------------------------
// lsfb_req_if
// Request channel: brightness and LED mask with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsfb_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] brightness;
	logic [7:0]  led_mask;

	modport source (output valid, output brightness, output led_mask, input ready);
	modport sink (input valid, input brightness, input led_mask, output ready);
endinterface

/* hdl/lsfb_byte_if.sv */
// ----------------------------------------------------------------------------
// lsfb_byte_if
// Frame byte channel: one strip byte per word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* hdl/lsfb_front.sv */
// ----------------------------------------------------------------------------
// lsfb_front
// Accepts requests, saturates brightness, fixes up the mask and splits the
// value into three colour bytes before pushing into the queue.
// ----------------------------------------------------------------------------
module lsfb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	lsfb_req_if.sink             req,
	input  lsfb_pkg::lsfb_qstat_t qstat,
	output logic                 push,
	output lsfb_pkg::lsfb_entry_t push_entry
);

	logic        valid_s1;
	logic [9:0]  v_s1;
	logic [7:0]  mask_s1;
	logic        take;
	logic [20:0] prod;
	logic [9:0]  quot;
	logic [9:0]  diff;
	logic [7:0]  col_b;

	assign req.ready = !valid_s1 || !qstat.full;
	assign take = req.valid && req.ready;
	assign push = valid_s1 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			v_s1 <= (req.brightness > lsfb_pkg::BRIGHT_MAX) ?
				lsfb_pkg::BRIGHT_MAX[9:0] : req.brightness[9:0];
			mask_s1 <= (req.led_mask == 8'h00) ? lsfb_pkg::ALL_LEDS : req.led_mask;
		end
	end

	// divide by three through a reciprocal multiply
	always_comb begin
		prod  = 21'(v_s1) * 21'(lsfb_pkg::RECIP3);
		quot  = 10'(prod >> lsfb_pkg::RECIP3_SHIFT);
		diff  = v_s1 - quot;
		col_b = diff[8:1];
		push_entry.col_a = quot[7:0];
		push_entry.col_b = col_b;
		push_entry.col_c = 8'(diff - {2'b00, col_b});
		push_entry.mask  = mask_s1;
	end

endmodule

/* hdl/lsfb_queue.sv */
// ----------------------------------------------------------------------------
// lsfb_queue
// Short queue of classified requests between front and serializer.
// ----------------------------------------------------------------------------
module lsfb_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lsfb_pkg::lsfb_entry_t push_entry,
	input  logic                  pop,
	output lsfb_pkg::lsfb_entry_t head,
	output lsfb_pkg::lsfb_qstat_t qstat
);

	localparam int PTR_W = (lsfb_pkg::QUEUE_DEPTH > 1) ? $clog2(lsfb_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(lsfb_pkg::QUEUE_DEPTH + 1);

	lsfb_pkg::lsfb_entry_t slot_q [lsfb_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_W'(lsfb_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(lsfb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(lsfb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* hdl/lsfb_serializer.sv */
// ----------------------------------------------------------------------------
// lsfb_serializer
// Walks the frame byte counter over the head request and drives the output
// register, one byte per cycle while frame.ready allows and a request waits.
// ----------------------------------------------------------------------------
module lsfb_serializer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsfb_pkg::lsfb_entry_t head,
	input  lsfb_pkg::lsfb_qstat_t qstat,
	output logic                  pop,
	lsfb_byte_if.source           frame
);

	logic [lsfb_pkg::CNT_W-1:0] cnt_q;
	logic                       out_valid_q;
	logic [7:0]                 byte_q;
	logic                       last_q;
	logic                       load;
	logic                       adv;
	logic                       is_last;
	logic [lsfb_pkg::CNT_W-1:0] idx;
	logic [lsfb_pkg::LED_W-1:0] led;
	logic                       lit;
	logic [7:0]                 next_byte;

	assign load    = !out_valid_q || frame.ready;
	assign adv     = load && !qstat.empty;
	assign is_last = (cnt_q == lsfb_pkg::CNT_W'(lsfb_pkg::FRAME_LEN - 1));
	assign pop     = adv && is_last;

	always_comb begin
		idx = cnt_q - lsfb_pkg::CNT_W'(lsfb_pkg::START_LEN);
		led = idx[2 +: lsfb_pkg::LED_W];
		lit = head.mask[led];
		next_byte = 8'h00;
		if (cnt_q >= lsfb_pkg::CNT_W'(lsfb_pkg::START_LEN) &&
			cnt_q < lsfb_pkg::CNT_W'(lsfb_pkg::START_LEN + 4 * lsfb_pkg::NUM_LEDS)) begin
			case (idx[1:0])
				2'd0: next_byte = lsfb_pkg::LED_HEADER;
				2'd1: next_byte = lit ? head.col_a : 8'h00;
				2'd2: next_byte = lit ? head.col_b : 8'h00;
				2'd3: next_byte = lit ? head.col_c : 8'h00;
				default: next_byte = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= adv;
			if (adv) begin
				cnt_q <= is_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= next_byte;
			last_q <= is_last;
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = byte_q;
	assign frame.last_byte  = last_q;

endmodule

/* hdl/led_strip_frame_builder_unit.sv */
// ----------------------------------------------------------------------------
// led_strip_frame_builder_unit
// Builds a serial LED strip frame from a brightness and mask request.
// ----------------------------------------------------------------------------
// usage:
//   req   - one word per frame: brightness (saturates at 765) and led_mask
//           (zero lights every LED). valid/ready handshake.
//   frame - 5*NUM_LEDS+8 words per request (48 for eight LEDs): four zero
//           start bytes, a header and three colour bytes per LED, zero
//           padding; last_byte marks the final padding byte.
//   the front stage registers the request, splits the brightness and parks
//   the result in a two-entry queue; the serializer emits one byte per cycle
//   from the queue head while frame.ready is high, so the first byte passes
//   the front register, a queue slot and the output register after
//   acceptance; frames follow each other without gaps, paced by its counter.
//   up to two requests queue behind the one being sent; req.ready drops
//   once both slots and the front register are taken.
//   when frame.ready is low the output register holds its word and the
//   counter stops; requests keep being accepted until the queue fills.
//   reset empties the queue and the output register and restarts the counter.
// ----------------------------------------------------------------------------
module led_strip_frame_builder_unit (
	input  logic        clk,
	input  logic        arst_n,
	lsfb_req_if.sink    req,
	lsfb_byte_if.source frame
);

	lsfb_pkg::lsfb_qstat_t qstat;
	lsfb_pkg::lsfb_entry_t push_entry;
	lsfb_pkg::lsfb_entry_t head;
	logic                  push;
	logic                  pop;

	lsfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	lsfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	lsfb_serializer u_serializer (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.frame  (frame)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue pop while empty");

	a_last_is_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.last_byte) |-> frame.frame_byte == 8'h00)
		else $error("last word is not a padding byte");

	a_pop_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (frame.valid && frame.last_byte))
		else $error("frame closed without last word");

endmodule
